// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock is clk, reset is rst in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define B64_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication checked in the same cycle.
`define B64_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/b64sd_pkg.sv
`timescale 1ns / 1ps

package b64sd_pkg;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // One unit of work for the back end: a finished quad or an error beat.
  typedef struct packed {
    logic        is_err;
    logic [23:0] word;
    logic        keep_mid;
    logic        keep_last;
    logic        eot;
  } cmd_t;

  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = 6'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r.val = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r.val = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r.val = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      r.val = 6'd62;
    end else if (ch == 8'h2F) begin
      r.val = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/b64sd_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64sd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_code,
  input  logic              end_of_text,
  input  logic              full,
  output logic              push,
  output b64sd_pkg::cmd_t   cmd
);
  import b64sd_pkg::*;

  logic [17:0] sextet_hold, sextet_hold_next;
  logic [1:0]  quad_position, quad_position_next;
  logic        third_was_pad, third_was_pad_next;
  logic        discarding, discarding_next;

  logic    accept;
  logic    pad;
  logic    char_ok;
  sextet_t sx;
  logic [5:0] cur_val;

  assign in_stall = full;
  assign accept   = in_valid && !full;
  assign pad      = (char_code == PadChar);
  assign sx       = sextet_of(char_code);
  // '=' is legal only in the third or fourth slot
  assign char_ok  = sx.ok || (pad && quad_position[1]);
  assign cur_val  = pad ? 6'd0 : sx.val;

  always_comb begin
    sextet_hold_next   = sextet_hold;
    quad_position_next = quad_position;
    third_was_pad_next = third_was_pad;
    discarding_next    = discarding;
    push               = 1'b0;
    cmd.is_err         = 1'b0;
    cmd.word           = {sextet_hold, cur_val};
    cmd.keep_mid       = !third_was_pad;
    cmd.keep_last      = !pad;
    cmd.eot            = end_of_text;
    if (accept) begin
      if (discarding) begin
        if (end_of_text) begin
          sextet_hold_next   = '0;
          quad_position_next = '0;
          third_was_pad_next = 1'b0;
          discarding_next    = 1'b0;
        end
      end else if (!char_ok) begin
        push               = 1'b1;
        cmd.is_err         = 1'b1;
        sextet_hold_next   = '0;
        quad_position_next = '0;
        third_was_pad_next = 1'b0;
        discarding_next    = !end_of_text;
      end else if (quad_position == 2'd3) begin
        push               = 1'b1;
        sextet_hold_next   = '0;
        quad_position_next = '0;
        third_was_pad_next = 1'b0;
      end else begin
        sextet_hold_next   = {sextet_hold[11:0], cur_val};
        quad_position_next = quad_position + 2'd1;
        if (quad_position == 2'd2) begin
          third_was_pad_next = pad;
        end
        // short message: end flag before the quad is complete
        if (end_of_text) begin
          push               = 1'b1;
          cmd.is_err         = 1'b1;
          sextet_hold_next   = '0;
          quad_position_next = '0;
          third_was_pad_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_hold   <= '0;
      quad_position <= '0;
      third_was_pad <= 1'b0;
      discarding    <= 1'b0;
    end else begin
      sextet_hold   <= sextet_hold_next;
      quad_position <= quad_position_next;
      third_was_pad <= third_was_pad_next;
      discarding    <= discarding_next;
    end
  end

  `B64_IMPLY(a_no_push_when_discarding, discarding, !push, "beat issued while discarding")
  `B64_IMPLY(a_no_push_when_full, full, !push, "push into full queue")

endmodule

// File: hdl/b64sd_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64sd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64sd_pkg::cmd_t wr_cmd,
  output logic            full,
  input  logic            pop,
  output b64sd_pkg::cmd_t rd_cmd,
  output logic            empty
);
  import b64sd_pkg::*;

  cmd_t              mem [FifoDepth];
  logic [FifoAw-1:0] wr_ptr;
  logic [FifoAw-1:0] rd_ptr;
  logic [FifoAw:0]   count;

  assign full   = (count == (FifoAw+1)'(FifoDepth));
  assign empty  = (count == '0);
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FifoAw+1)'(push) - (FifoAw+1)'(pop);
    end
  end

  `B64_CHECK(a_count_bound, count <= (FifoAw+1)'(FifoDepth), "queue count overflow")
  `B64_IMPLY(a_pop_nonempty, pop, !empty, "pop from empty queue")

endmodule

// File: hdl/b64sd_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64sd_back (
  input  logic            clk,
  input  logic            rst,
  input  b64sd_pkg::cmd_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      data_byte,
  output logic            error,
  output logic            last
);
  import b64sd_pkg::*;

  localparam logic [1:0] StepHi  = 2'd0;
  localparam logic [1:0] StepMid = 2'd1;
  localparam logic [1:0] StepLo  = 2'd2;

  logic [1:0] step, step_next;
  logic [7:0] beat_byte;
  logic       done;
  logic       advance;
  logic       load;

  always_comb begin
    beat_byte = 8'd0;
    done      = 1'b1;
    step_next = StepHi;
    if (!head.is_err) begin
      unique case (step)
        StepHi: begin
          beat_byte = head.word[23:16];
          if (head.keep_mid) begin
            done      = 1'b0;
            step_next = StepMid;
          end else if (head.keep_last) begin
            done      = 1'b0;
            step_next = StepLo;
          end
        end
        StepMid: begin
          beat_byte = head.word[15:8];
          if (head.keep_last) begin
            done      = 1'b0;
            step_next = StepLo;
          end
        end
        default: begin
          beat_byte = head.word[7:0];
        end
      endcase
    end
  end

  assign advance = !out_valid || !out_stall;
  assign load    = advance && !empty;
  assign pop     = load && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= StepHi;
    end else if (advance) begin
      out_valid <= !empty;
      if (!empty) begin
        step <= done ? StepHi : step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_byte <= beat_byte;
      error     <= head.is_err;
      last      <= head.is_err || (head.eot && done);
    end
  end

  `B64_IMPLY(a_err_beat_form, out_valid && error, last && (data_byte == 8'd0), "bad error beat")

endmodule

// File: hdl/base64_stream_decoder_top.sv
// Base64 decoder, one character beat accepted per cycle when the queue has room.
// A quad's first byte is written into the queue when its fourth character is
// accepted, then registered at the output; further bytes of the quad follow
// one per cycle while out_stall is low, at most 3 bytes per quad in all.
// Reset (rst, synchronous): clears quad state, discard flag, queue and out_valid.
`timescale 1ns / 1ps

module base64_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       error,
  output logic       last
);
  import b64sd_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  b64sd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .full        (full),
    .push        (push),
    .cmd         (wr_cmd)
  );

  b64sd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .full   (full),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .empty  (empty)
  );

  b64sd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (rd_cmd),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_byte (data_byte),
    .error     (error),
    .last      (last)
  );

endmodule

// File: verif/base64_stream_decoder_top_tb.sv
`timescale 1ns / 1ps

module base64_stream_decoder_top_tb;

  localparam logic [7:0] PadCode    = 8'h3D;
  localparam int         CycleLimit = 200000;
  localparam int         DrainWait  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       lst;
  } dec_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_code = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] data_byte;
  logic       error;
  logic       last;

  // Decoder shadow state
  logic [17:0] held_sextets = '0;
  logic [1:0]  quad_pos = '0;
  logic        third_pad = 1'b0;
  logic        skip_to_end = 1'b0;

  dec_beat_t bytes_due[$];
  int        mismatches = 0;
  int        chars_sent = 0;
  int        cycle_count = 0;
  int        stall_left = 0;
  int unsigned stall_roll;
  bit        no_gaps = 1'b0;

  base64_stream_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .char_code   (char_code),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .error       (error),
    .last        (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Returns the 6-bit alphabet value, or -1 for anything else.
  function automatic int alpha_value(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 26;
    if (ch >= "0" && ch <= "9") return ch - "0" + 52;
    if (ch == "+") return 62;
    if (ch == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] random_alpha_char();
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "+";
    return "/";
  endfunction

  function automatic void clear_quad();
    held_sextets = '0;
    quad_pos     = '0;
    third_pad    = 1'b0;
  endfunction

  function automatic void push_error(input logic eot);
    clear_quad();
    skip_to_end = !eot;
    bytes_due.push_back('{data: 8'h00, err: 1'b1, lst: 1'b1});
  endfunction

  function automatic void decode_char(input logic [7:0] ch, input logic eot);
    int          v;
    logic        is_pad;
    logic [23:0] word;
    logic        keep_mid;
    logic        keep_last;
    v      = alpha_value(ch);
    is_pad = (ch == PadCode);
    if (skip_to_end) begin
      if (eot) begin
        clear_quad();
        skip_to_end = 1'b0;
      end
      return;
    end
    // pad only counts as legal in the back half of a quad
    if (v < 0 && !(is_pad && quad_pos >= 2)) begin
      push_error(eot);
      return;
    end
    if (quad_pos != 2'd3) begin
      held_sextets = {held_sextets[11:0], is_pad ? 6'd0 : 6'(v)};
      if (quad_pos == 2'd2) third_pad = is_pad;
      quad_pos = quad_pos + 2'd1;
      if (eot) push_error(eot);
      return;
    end
    word      = {held_sextets, is_pad ? 6'd0 : 6'(v)};
    keep_mid  = !third_pad;
    keep_last = !is_pad;
    bytes_due.push_back('{data: word[23:16], err: 1'b0,
                          lst: eot && !keep_mid && !keep_last});
    if (keep_mid)
      bytes_due.push_back('{data: word[15:8], err: 1'b0, lst: eot && !keep_last});
    if (keep_last)
      bytes_due.push_back('{data: word[7:0], err: 1'b0, lst: eot});
    clear_quad();
  endfunction

  function automatic void check_output_beat();
    dec_beat_t want;
    if (bytes_due.size() == 0) begin
      $error("output beat with nothing due: data_byte=%h error=%b last=%b",
             data_byte, error, last);
      mismatches++;
      return;
    end
    want = bytes_due.pop_front();
    if (data_byte !== want.data) begin
      $error("data_byte: expected %h, got %h", want.data, data_byte);
      mismatches++;
    end
    if (error !== want.err) begin
      $error("error: expected %b, got %b", want.err, error);
      mismatches++;
    end
    if (last !== want.lst) begin
      $error("last: expected %b, got %b", want.lst, last);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) decode_char(char_code, end_of_text);
      if (out_valid && !out_stall) check_output_beat();
    end
  end

  // Output backpressure: runs of ready or stalled, mostly short, a few long
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 10) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(30, 80);
      end else if (stall_roll < 55) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 5);
      end else if (stall_roll < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(8, 30);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic eot);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    char_code   <= ch;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input logic eot_at_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], eot_at_end && (i == s.len() - 1));
  endtask

  task automatic test_full_quads();
    send_text("TWFu", 1'b0);
    send_text("AZaz09+/", 1'b1);
  endtask

  task automatic test_padding();
    // pad in third slot with a real fourth char, then two pads closing the message
    send_text("QQ=BTQ==", 1'b1);
    send_text("TWE=", 1'b1);
  endtask

  task automatic test_bad_chars();
    send_text("Zm", 1'b1);               // short message
    send_char(8'hFF, 1'b0);              // bad char, rest dropped
    send_char("/", 1'b0);
    send_char(8'h00, 1'b1);
    send_text("+=x", 1'b1);              // pad in second slot
    send_text("=", 1'b1);                // pad in first slot, ends message
    send_text("AAA", 1'b0);
    send_char(8'h00, 1'b1);              // bad fourth char on final beat
  endtask

  task automatic test_random_messages();
    int         first;
    int         quads;
    int         len;
    logic [7:0] ch;
    first = chars_sent;
    while (chars_sent - first < 70) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        quads = $urandom_range(1, 4);
        for (int q = 0; q < quads; q++) begin
          for (int p = 0; p < 4; p++) begin
            ch = random_alpha_char();
            if (p == 2 && $urandom_range(0, 6) == 0) ch = PadCode;
            if (p == 3 && $urandom_range(0, 4) == 0) ch = PadCode;
            send_char(ch, (q == quads - 1) && (p == 3));
          end
        end
      end else begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 2) == 0)
            ch = 8'($urandom_range(0, 255));
          else if ($urandom_range(0, 5) == 0)
            ch = PadCode;
          else
            ch = random_alpha_char();
          send_char(ch, i == len - 1);
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_full_quads();
    test_padding();
    test_bad_chars();
    test_random_messages();
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
